// ===== rtl/poly_gcd_mod_prime_defines.svh =====
// Assertion macros for the polynomial gcd block.
`ifndef POLY_GCD_MOD_PRIME_DEFINES_SVH
`define POLY_GCD_MOD_PRIME_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every edge out of reset.
`define PGCD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("pgcd assertion failed");

// Condition in one cycle forces a result in the next.
`define PGCD_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
		else $error("pgcd assertion failed");

// Condition must never be seen.
`define PGCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("pgcd assertion failed");

`else

`define PGCD_ASSERT(lbl, clk, rstn, prop)
`define PGCD_ASSERT_NEXT(lbl, clk, rstn, cond, res)
`define PGCD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/pgcd_pkg.sv =====
package pgcd_pkg;

	localparam int MAX_DEGREE = 31;
	localparam int COEF_BITS  = 16;
	localparam int CAP        = MAX_DEGREE + 1;
	localparam int CNT_W      = $clog2(CAP + 1);
	localparam int ADDR_W     = $clog2(CAP);
	localparam int MM_CNT_W   = $clog2(COEF_BITS + 1);
	localparam int MOD_BITS   = 16;
	localparam logic [MOD_BITS-1:0] MOD_RESET = 16'd65521;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// Item classes seen by the back end
	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;

	typedef struct packed {
		logic                 mode;
		logic [COEF_BITS-1:0] coefficient;
		logic                 last;
	} in_word_t;

	typedef struct packed {
		logic [COEF_BITS-1:0] gcd_coefficient;
		logic                 last_coefficient;
		logic                 zero_result;
		logic                 overflow;
	} out_word_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 last;
		logic [COEF_BITS-1:0] coefficient;
	} item_t;

	typedef struct packed {
		logic                 start;
		logic [COEF_BITS-1:0] x;
		logic [COEF_BITS-1:0] y;
	} mm_req_t;

	typedef struct packed {
		logic                 done;
		logic [COEF_BITS-1:0] res;
	} mm_rsp_t;

endpackage

// ===== rtl/poly_gcd_mod_prime.sv =====
// Greatest common divisor of two polynomials over GF(p).
// Input channel (item_valid / item_stall / item): one coefficient per word,
// lowest degree first; mode 0 loads the first operand, mode 1 the second.
// The last word of the second operand starts the computation.
// Output channel (result_valid / result_stall / result): the monic gcd,
// lowest degree first, last_coefficient on the top word; a zero gcd comes
// out as one word with zero_result set.
// Config channel (cfg_valid / cfg_ready / cfg_data): the modulus, written
// while the block is idle; cfg_ready is always high.
// Throughput: a four-word queue takes input words one per cycle while not
// full; the back end reduces each coefficient with the 16-step shift-and-add
// modular multiplier before it takes the next word. The gcd itself is built
// of the same multiplies: those of the inverse of each divisor's lead term,
// one per multiply-subtract of each remainder step, and one per output word.
// Reset clears counts, flags and the queue and sets the modulus to 65521;
// the coefficient stores are not cleared. A stalled result holds its word
// and the back end waits, while the queue still takes input until full.
`include "poly_gcd_mod_prime_defines.svh"

module poly_gcd_mod_prime (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  pgcd_pkg::in_word_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output pgcd_pkg::out_word_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pgcd_pkg::MOD_BITS-1:0] cfg_data
);

	logic [pgcd_pkg::MOD_BITS-1:0] modulus_q;
	logic                          q_valid, q_pop;
	pgcd_pkg::item_t               q_word;
	logic                          zero_ok;

	assign cfg_ready = 1'b1;

	// Hold the modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= pgcd_pkg::MOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data;
		end
	end

	pgcd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
	);

	pgcd_back u_back (
		.clk(clk), .arst_n(arst_n), .modulus(modulus_q),
		.q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	// A zero gcd word is a single last word of value zero
	assign zero_ok = !(result_valid && result.zero_result) ||
		(result.last_coefficient && (result.gcd_coefficient == '0));

	`PGCD_ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_valid)
	`PGCD_ASSERT_NEXT(a_push_seen, clk, arst_n, item_valid && !item_stall, q_valid)
	`PGCD_ASSERT(a_zero_last, clk, arst_n, zero_ok)

endmodule

// ===== rtl/pgcd_ram.sv =====
module pgcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pgcd_mulmod.sv =====
module pgcd_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pgcd_pkg::mm_req_t             req,
	input  logic [pgcd_pkg::MOD_BITS-1:0] modulus,
	output pgcd_pkg::mm_rsp_t             rsp
);

	logic [pgcd_pkg::COEF_BITS-1:0] r_q, x_q, y_q;
	logic [pgcd_pkg::MOD_BITS-1:0]  m_q;
	logic [pgcd_pkg::MM_CNT_W-1:0]  cnt_q;
	logic                           busy_q, done_q;
	logic [pgcd_pkg::COEF_BITS:0]   dbl, dbl_red, sum, sum_red;

	// One bit of x per cycle: r = 2r + bit*y, both reduced by one subtract
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = dbl_red + (x_q[pgcd_pkg::COEF_BITS-1] ? {1'b0, y_q} : '0);
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pgcd_pkg::MM_CNT_W'(pgcd_pkg::COEF_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pgcd_pkg::MM_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			x_q <= req.x;
			y_q <= req.y;
			m_q <= modulus;
		end else if (busy_q) begin
			r_q <= sum_red[pgcd_pkg::COEF_BITS-1:0];
			x_q <= {x_q[pgcd_pkg::COEF_BITS-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = r_q;

endmodule

// ===== rtl/pgcd_front.sv =====
module pgcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  pgcd_pkg::in_word_t item,
	output logic               q_valid,
	output pgcd_pkg::item_t    q_word,
	input  logic               q_pop
);

	pgcd_pkg::item_t                mem_q [pgcd_pkg::QDEPTH];
	logic [pgcd_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [pgcd_pkg::QPTR_W:0]      cnt_q;
	logic                           push;
	pgcd_pkg::item_t                cls;

	// Classify the incoming word
	always_comb begin
		cls.last        = item.last;
		cls.coefficient = item.coefficient;
		if (!item.mode) begin
			cls.kind = pgcd_pkg::KIND_FIRST;
		end else if (item.last) begin
			cls.kind = pgcd_pkg::KIND_RUN;
		end else begin
			cls.kind = pgcd_pkg::KIND_SECOND;
		end
	end

	assign item_stall = (cnt_q == (pgcd_pkg::QPTR_W+1)'(pgcd_pkg::QDEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (cnt_q != '0);
	assign q_word     = mem_q[rd_q];

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

endmodule

// ===== rtl/pgcd_back.sv =====
module pgcd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pgcd_pkg::MOD_BITS-1:0] modulus,
	input  logic                          q_valid,
	input  pgcd_pkg::item_t               q_word,
	output logic                          q_pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output pgcd_pkg::out_word_t           result
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_RED     = 5'd1;
	localparam logic [4:0] S_TR_RD   = 5'd2;
	localparam logic [4:0] S_TR_CHK  = 5'd3;
	localparam logic [4:0] S_OUTER   = 5'd4;
	localparam logic [4:0] S_INV_RD  = 5'd5;
	localparam logic [4:0] S_INV_LD  = 5'd6;
	localparam logic [4:0] S_POW_SQ  = 5'd7;
	localparam logic [4:0] S_POW_MUL = 5'd8;
	localparam logic [4:0] S_Q_RD    = 5'd9;
	localparam logic [4:0] S_Q_LD    = 5'd10;
	localparam logic [4:0] S_Q_MUL   = 5'd11;
	localparam logic [4:0] S_I_RD    = 5'd12;
	localparam logic [4:0] S_I_LD    = 5'd13;
	localparam logic [4:0] S_I_MUL   = 5'd14;
	localparam logic [4:0] S_Z_WR    = 5'd15;
	localparam logic [4:0] S_FIN     = 5'd16;
	localparam logic [4:0] S_ZOUT    = 5'd17;
	localparam logic [4:0] S_E_RD    = 5'd18;
	localparam logic [4:0] S_E_LD    = 5'd19;
	localparam logic [4:0] S_E_MUL   = 5'd20;
	localparam logic [4:0] S_E_OUT   = 5'd21;

	localparam int CW = pgcd_pkg::COEF_BITS;
	localparam int NW = pgcd_pkg::CNT_W;
	localparam int AW = pgcd_pkg::ADDR_W;
	localparam logic [NW-1:0] CAP_N = NW'(pgcd_pkg::CAP);

	logic [4:0]    state_q;
	logic [NW-1:0] fcnt_q, scnt_q, la_q, lb_q, i_q;
	logic [AW-1:0] k_q;
	logic          phase_q, ovf_q, ovf_out_q, ptr_q;
	logic          init_q, trim_b_q, inv_fin_q;
	pgcd_pkg::item_t word_q;
	logic [CW-1:0] q_q, linv_q, cur_a_q, pw_r_q, pw_v_q;
	logic [pgcd_pkg::MOD_BITS-1:0] pw_e_q;
	logic [pgcd_pkg::MM_CNT_W-1:0] pw_cnt_q;
	pgcd_pkg::mm_req_t mm_req_q;
	pgcd_pkg::mm_rsp_t mm_rsp;
	pgcd_pkg::out_word_t res_q;
	logic          res_valid_q;

	logic [pgcd_pkg::MOD_BITS-1:0] m_eff;
	logic [NW-1:0] f_base, f_next, s_next, tr_len;
	logic          f_room, s_room, tr_zero, tr_end, slot_free, pw_last;
	logic          a_we, b_we;
	logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
	logic [CW-1:0] a_wdata, a_rdata, b_rdata, sub_val;
	logic [CW:0]   sub_wide;
	logic          r0_we, r1_we;
	logic [AW-1:0] r0_waddr, r1_waddr, r0_raddr, r1_raddr;
	logic [CW-1:0] r0_wdata, r1_wdata, r0_rdata, r1_rdata;

	// Clamp the modulus to at least two
	assign m_eff = (modulus < 16'd2) ? 16'd2 : modulus;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign slot_free = !res_valid_q || !result_stall;
	assign pw_last   = (pw_cnt_q == pgcd_pkg::MM_CNT_W'(1));

	// Load counters
	assign f_base = phase_q ? '0 : fcnt_q;
	assign f_room = (f_base < CAP_N);
	assign f_next = f_room ? f_base + 1'b1 : f_base;
	assign s_room = (scnt_q < CAP_N);
	assign s_next = s_room ? scnt_q + 1'b1 : scnt_q;

	// Trim control
	assign tr_len  = trim_b_q ? lb_q : la_q;
	assign tr_zero = trim_b_q ? (b_rdata == '0) : (a_rdata == '0);
	assign tr_end  = ((state_q == S_TR_RD) && (tr_len == '0)) ||
		((state_q == S_TR_CHK) && !tr_zero);

	// a[k] - q*d[i] mod m
	always_comb begin
		if (cur_a_q >= mm_rsp.res) begin
			sub_wide = {1'b0, cur_a_q} - {1'b0, mm_rsp.res};
		end else begin
			sub_wide = ({1'b0, cur_a_q} + {1'b0, m_eff}) - {1'b0, mm_rsp.res};
		end
		sub_val = sub_wide[CW-1:0];
	end

	// Store ports, seen as A (dividend) and B (divisor) sides
	always_comb begin
		a_we    = 1'b0;
		b_we    = 1'b0;
		a_waddr = f_base[AW-1:0];
		b_waddr = scnt_q[AW-1:0];
		a_wdata = mm_rsp.res;
		a_raddr = AW'(la_q - 1'b1);
		b_raddr = AW'(lb_q - 1'b1);
		if (state_q == S_RED && mm_rsp.done) begin
			a_we = (word_q.kind == pgcd_pkg::KIND_FIRST) && f_room;
			b_we = (word_q.kind != pgcd_pkg::KIND_FIRST) && s_room;
		end
		if (state_q == S_I_MUL && mm_rsp.done) begin
			a_we    = 1'b1;
			a_waddr = k_q;
			a_wdata = sub_val;
		end
		if (state_q == S_Z_WR) begin
			a_we    = 1'b1;
			a_waddr = AW'(la_q - 1'b1);
			a_wdata = '0;
		end
		if (state_q == S_I_RD) begin
			a_raddr = k_q;
			b_raddr = i_q[AW-1:0];
		end
		if (state_q == S_E_RD) begin
			a_raddr = i_q[AW-1:0];
		end
	end

	// Map sides onto the two stores by the swap pointer
	always_comb begin
		r0_we    = ptr_q ? b_we : a_we;
		r1_we    = ptr_q ? a_we : b_we;
		r0_waddr = ptr_q ? b_waddr : a_waddr;
		r1_waddr = ptr_q ? a_waddr : b_waddr;
		r0_wdata = ptr_q ? mm_rsp.res : a_wdata;
		r1_wdata = ptr_q ? a_wdata : mm_rsp.res;
		r0_raddr = ptr_q ? b_raddr : a_raddr;
		r1_raddr = ptr_q ? a_raddr : b_raddr;
		a_rdata  = ptr_q ? r1_rdata : r0_rdata;
		b_rdata  = ptr_q ? r0_rdata : r1_rdata;
	end

	pgcd_ram #(.WIDTH(CW), .DEPTH(pgcd_pkg::CAP)) u_ram0 (
		.clk(clk), .we(r0_we), .waddr(r0_waddr), .wdata(r0_wdata),
		.raddr(r0_raddr), .rdata(r0_rdata)
	);

	pgcd_ram #(.WIDTH(CW), .DEPTH(pgcd_pkg::CAP)) u_ram1 (
		.clk(clk), .we(r1_we), .waddr(r1_waddr), .wdata(r1_wdata),
		.raddr(r1_raddr), .rdata(r1_rdata)
	);

	pgcd_mulmod u_mulmod (
		.clk(clk), .arst_n(arst_n), .req(mm_req_q), .modulus(m_eff), .rsp(mm_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fcnt_q      <= '0;
			scnt_q      <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			i_q         <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			ovf_q       <= 1'b0;
			ovf_out_q   <= 1'b0;
			ptr_q       <= 1'b0;
			init_q      <= 1'b0;
			trim_b_q    <= 1'b0;
			inv_fin_q   <= 1'b0;
			pw_cnt_q    <= '0;
			word_q      <= '0;
			q_q         <= '0;
			linv_q      <= '0;
			cur_a_q     <= '0;
			pw_r_q      <= '0;
			pw_v_q      <= '0;
			pw_e_q      <= '0;
			mm_req_q    <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Drop the one-cycle multiplier start
			if (mm_req_q.start) begin
				mm_req_q.start <= 1'b0;
			end
			// Drop a taken word unless a new one replaces it
			if (res_valid_q && !result_stall && state_q != S_ZOUT && state_q != S_E_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						word_q         <= q_word;
						mm_req_q.start <= 1'b1;
						mm_req_q.x     <= q_word.coefficient;
						mm_req_q.y     <= CW'(1);
						state_q        <= S_RED;
					end
				end
				S_RED: begin
					if (mm_rsp.done) begin
						if (word_q.kind == pgcd_pkg::KIND_FIRST) begin
							fcnt_q  <= f_next;
							ovf_q   <= ovf_q | !f_room;
							phase_q <= word_q.last;
							state_q <= S_IDLE;
						end else begin
							scnt_q <= s_next;
							ovf_q  <= ovf_q | !s_room;
							if (word_q.kind == pgcd_pkg::KIND_RUN) begin
								la_q     <= fcnt_q;
								lb_q     <= s_next;
								init_q   <= 1'b1;
								trim_b_q <= 1'b0;
								state_q  <= S_TR_RD;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_TR_RD, S_TR_CHK: begin
					if (tr_end) begin
						if (init_q && !trim_b_q) begin
							trim_b_q <= 1'b1;
							state_q  <= S_TR_RD;
						end else if (init_q) begin
							init_q  <= 1'b0;
							state_q <= S_OUTER;
						end else begin
							state_q <= S_Q_RD;
						end
					end else if (state_q == S_TR_RD) begin
						state_q <= S_TR_CHK;
					end else begin
						if (trim_b_q) begin
							lb_q <= lb_q - 1'b1;
						end else begin
							la_q <= la_q - 1'b1;
						end
						state_q <= S_TR_RD;
					end
				end
				S_OUTER: begin
					if (lb_q == '0) begin
						state_q <= S_FIN;
					end else begin
						inv_fin_q <= 1'b0;
						state_q   <= S_INV_RD;
					end
				end
				S_INV_RD: begin
					state_q <= S_INV_LD;
				end
				S_INV_LD: begin
					pw_v_q         <= inv_fin_q ? a_rdata : b_rdata;
					pw_r_q         <= CW'(1);
					pw_e_q         <= m_eff - 16'd2;
					pw_cnt_q       <= pgcd_pkg::MM_CNT_W'(pgcd_pkg::MOD_BITS);
					mm_req_q.start <= 1'b1;
					mm_req_q.x     <= CW'(1);
					mm_req_q.y     <= CW'(1);
					state_q        <= S_POW_SQ;
				end
				S_POW_SQ, S_POW_MUL: begin
					if (mm_rsp.done) begin
						pw_r_q <= mm_rsp.res;
						if (state_q == S_POW_SQ && pw_e_q[pgcd_pkg::MOD_BITS-1]) begin
							mm_req_q.start <= 1'b1;
							mm_req_q.x     <= mm_rsp.res;
							mm_req_q.y     <= pw_v_q;
							state_q        <= S_POW_MUL;
						end else begin
							pw_e_q   <= {pw_e_q[pgcd_pkg::MOD_BITS-2:0], 1'b0};
							pw_cnt_q <= pw_cnt_q - 1'b1;
							if (pw_last) begin
								linv_q  <= mm_rsp.res;
								i_q     <= '0;
								state_q <= inv_fin_q ? S_E_RD : S_Q_RD;
							end else begin
								mm_req_q.start <= 1'b1;
								mm_req_q.x     <= mm_rsp.res;
								mm_req_q.y     <= mm_rsp.res;
								state_q        <= S_POW_SQ;
							end
						end
					end
				end
				S_Q_RD: begin
					if (la_q == '0 || la_q < lb_q) begin
						ptr_q   <= !ptr_q;
						la_q    <= lb_q;
						lb_q    <= la_q;
						state_q <= S_OUTER;
					end else begin
						state_q <= S_Q_LD;
					end
				end
				S_Q_LD: begin
					mm_req_q.start <= 1'b1;
					mm_req_q.x     <= a_rdata;
					mm_req_q.y     <= linv_q;
					state_q        <= S_Q_MUL;
				end
				S_Q_MUL: begin
					if (mm_rsp.done) begin
						q_q     <= mm_rsp.res;
						i_q     <= '0;
						k_q     <= AW'(la_q - lb_q);
						state_q <= S_I_RD;
					end
				end
				S_I_RD: begin
					state_q <= S_I_LD;
				end
				S_I_LD: begin
					cur_a_q        <= a_rdata;
					mm_req_q.start <= 1'b1;
					mm_req_q.x     <= q_q;
					mm_req_q.y     <= b_rdata;
					state_q        <= S_I_MUL;
				end
				S_I_MUL: begin
					if (mm_rsp.done) begin
						i_q <= i_q + 1'b1;
						k_q <= k_q + 1'b1;
						state_q <= (NW'(i_q + 1'b1) == lb_q) ? S_Z_WR : S_I_RD;
					end
				end
				S_Z_WR: begin
					la_q     <= la_q - 1'b1;
					trim_b_q <= 1'b0;
					state_q  <= S_TR_RD;
				end
				S_FIN: begin
					ovf_out_q <= ovf_q;
					fcnt_q    <= '0;
					scnt_q    <= '0;
					ovf_q     <= 1'b0;
					phase_q   <= 1'b0;
					if (la_q == '0) begin
						state_q <= S_ZOUT;
					end else begin
						inv_fin_q <= 1'b1;
						state_q   <= S_INV_RD;
					end
				end
				S_ZOUT: begin
					if (slot_free) begin
						res_valid_q            <= 1'b1;
						res_q.gcd_coefficient  <= '0;
						res_q.last_coefficient <= 1'b1;
						res_q.zero_result      <= 1'b1;
						res_q.overflow         <= ovf_out_q;
						state_q                <= S_IDLE;
					end
				end
				S_E_RD: begin
					state_q <= S_E_LD;
				end
				S_E_LD: begin
					mm_req_q.start <= 1'b1;
					mm_req_q.x     <= a_rdata;
					mm_req_q.y     <= linv_q;
					state_q        <= S_E_MUL;
				end
				S_E_MUL: begin
					if (mm_rsp.done) begin
						state_q <= S_E_OUT;
					end
				end
				S_E_OUT: begin
					if (slot_free) begin
						res_valid_q            <= 1'b1;
						res_q.gcd_coefficient  <= mm_rsp.res;
						res_q.last_coefficient <= (NW'(i_q + 1'b1) == la_q);
						res_q.zero_result      <= 1'b0;
						res_q.overflow         <= ovf_out_q;
						i_q                    <= i_q + 1'b1;
						state_q <= (NW'(i_q + 1'b1) == la_q) ? S_IDLE : S_E_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== tb/tb_poly_gcd_mod_prime.sv =====
`timescale 1ns / 100ps

module tb_poly_gcd_mod_prime;
	import pgcd_pkg::*;

	localparam int MOD_W     = 16;
	localparam int LIMIT     = 4000000;
	localparam int SETTLE    = 200;
	localparam int MAX_LEN   = 6;
	localparam int HOLD_LEN  = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	in_word_t             item;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	out_word_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [MOD_W-1:0]     cfg_data;

	// model state
	logic [MOD_W-1:0]     field_mod;
	logic [COEF_BITS-1:0] first_coefs [CAP];
	logic [COEF_BITS-1:0] second_coefs [CAP];
	int                   first_len;
	int                   second_len;
	bit                   trunc_seen;
	bit                   first_closed;

	out_word_t            gcd_words_q[$];
	int                   errors = 0;
	int                   words_sent;
	int                   cycles = 0;
	int                   send_idle_pct;
	int                   stall_pct;
	bit                   hold_req = 1'b0;
	bit                   hold_seen = 1'b0;
	int                   hold_left = 0;

	poly_gcd_mod_prime dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint unsigned eff_mod();
		return (field_mod < 2) ? 64'd2 : 64'(field_mod);
	endfunction

	function automatic longint unsigned pow_field(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned r;
		r = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0]) r = (r * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return r;
	endfunction

	// Advance the model by one accepted word; queue any gcd words it yields.
	function automatic void predict_word(in_word_t w);
		longint unsigned m, c, linv, q, sub;
		longint unsigned a [CAP];
		longint unsigned b [CAP];
		longint unsigned t [CAP];
		int la, lb, lr, shift;
		bit ovf;
		out_word_t o;
		m = eff_mod();
		c = 64'(w.coefficient) % m;
		if (!w.mode) begin
			if (first_closed) begin
				first_len = 0;
				first_closed = 0;
			end
			if (first_len < CAP) begin
				first_coefs[first_len] = c[COEF_BITS-1:0];
				first_len++;
			end else trunc_seen = 1;
			if (w.last) first_closed = 1;
			return;
		end
		if (second_len < CAP) begin
			second_coefs[second_len] = c[COEF_BITS-1:0];
			second_len++;
		end else trunc_seen = 1;
		if (!w.last) return;

		for (int i = 0; i < CAP; i++) begin
			a[i] = (i < first_len) ? 64'(first_coefs[i]) : 0;
			b[i] = (i < second_len) ? 64'(second_coefs[i]) : 0;
		end
		la = first_len;
		while (la > 0 && a[la-1] == 0) la--;
		lb = second_len;
		while (lb > 0 && b[lb-1] == 0) lb--;
		// Euclid: a := a mod b, then swap
		while (lb > 0) begin
			linv = pow_field(b[lb-1], m - 2, m);
			lr = la;
			while (lr > 0 && lr >= lb) begin
				shift = lr - lb;
				q = (a[lr-1] * linv) % m;
				for (int i = 0; i < lb; i++) begin
					sub = (q * b[i]) % m;
					a[i+shift] = (a[i+shift] + m - sub) % m;
				end
				a[lr-1] = 0;
				lr--;
				while (lr > 0 && a[lr-1] == 0) lr--;
			end
			t = a;
			a = b;
			b = t;
			la = lb;
			lb = lr;
		end
		ovf = trunc_seen;
		first_len = 0;
		second_len = 0;
		trunc_seen = 0;
		first_closed = 0;

		if (la == 0) begin
			o = '{gcd_coefficient: '0, last_coefficient: 1'b1, zero_result: 1'b1,
				overflow: ovf};
			gcd_words_q.push_back(o);
			return;
		end
		linv = pow_field(a[la-1], m - 2, m);
		for (int i = 0; i < la; i++) begin
			q = (a[i] * linv) % m;
			o.gcd_coefficient  = q[COEF_BITS-1:0];
			o.last_coefficient = (i == la - 1);
			o.zero_result      = 1'b0;
			o.overflow         = ovf;
			gcd_words_q.push_back(o);
		end
	endfunction

	// Drive one word, hold it until accepted.
	task automatic send_word(in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_word(w);
		words_sent++;
	endtask

	task automatic send_poly(bit mode, logic [COEF_BITS-1:0] coefs[$], bit close);
		in_word_t w;
		for (int i = 0; i < coefs.size(); i++) begin
			w.mode        = mode;
			w.coefficient = coefs[i];
			w.last        = close && (i == coefs.size() - 1);
			send_word(w);
		end
	endtask

	function automatic logic [COEF_BITS-1:0] rand_coef();
		case ($urandom_range(3))
			0: return '0;
			1: return COEF_BITS'($urandom);
			2: return COEF_BITS'($urandom_range(10));
			default: return COEF_BITS'(16'hFFFF - $urandom_range(20));
		endcase
	endfunction

	// One operand pair, mostly well formed, sometimes broken.
	task automatic send_pair(int maxlen);
		logic [COEF_BITS-1:0] a[$];
		logic [COEF_BITS-1:0] b[$];
		logic [COEF_BITS-1:0] junk[$];
		longint unsigned m, r;
		int kind, la, lb;
		kind = $urandom_range(99);
		m = eff_mod();
		la = (kind >= 95 && kind <= 96) ? $urandom_range(CAP + 1, CAP + 4)
			: $urandom_range(1, maxlen);
		for (int i = 0; i < la; i++) a.push_back((kind >= 97) ? '0 : rand_coef());
		if (kind < 25 && la < CAP) begin
			// second operand shares the factor a: b = a * (x + r)
			r = $urandom_range(int'(m - 1));
			for (int i = 0; i <= la; i++) begin
				longint unsigned lo, hi;
				lo = (i < la) ? (64'(a[i]) % m) : 0;
				hi = (i > 0) ? (64'(a[i-1]) % m) : 0;
				b.push_back(COEF_BITS'((hi + r * lo) % m));
			end
		end else begin
			lb = $urandom_range(1, maxlen);
			for (int i = 0; i < lb; i++) b.push_back(rand_coef());
		end
		if (kind >= 90 && kind <= 92) begin
			for (int i = 0; i < $urandom_range(1, 3); i++) junk.push_back(rand_coef());
			send_poly(0, junk, 1);
		end
		send_poly(0, a, !(kind >= 93 && kind <= 94));
		send_poly(1, b, 1);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (gcd_words_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		field_mod = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stall, or a counted hold-off.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_LEN - 1;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted gcd word with the oldest prediction.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (gcd_words_q.size() == 0) begin
				$display("%0t unexpected word: expected none, got %h", $time, result);
				errors++;
			end else begin
				want = gcd_words_q.pop_front();
				if (result.gcd_coefficient !== want.gcd_coefficient ||
						result.last_coefficient !== want.last_coefficient ||
						result.zero_result !== want.zero_result ||
						result.overflow !== want.overflow) begin
					$display({"%0t mismatch: expected coef %0d last %b zero %b ovf %b,",
						" got coef %0d last %b zero %b ovf %b"},
						$time, want.gcd_coefficient, want.last_coefficient, want.zero_result,
						want.overflow, result.gcd_coefficient, result.last_coefficient,
						result.zero_result, result.overflow);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_poly(0, '{16'd0}, 1);
		send_poly(1, '{16'd0}, 1);
		send_poly(0, '{16'hFFFF, 16'd1}, 1);
		send_poly(1, '{16'd2, 16'd1}, 1);
		// reopen the first operand after it was closed
		send_poly(0, '{16'd5}, 1);
		send_poly(0, '{16'd3, 16'd1}, 1);
		send_poly(1, '{16'd1, 16'd1}, 1);
		// first operand left open
		send_poly(0, '{16'd7, 16'd9}, 0);
		send_poly(1, '{16'd1, 16'hFFFF}, 1);
		// empty first operand
		send_poly(1, '{16'd0, 16'd0, 16'd4}, 1);
	endtask

	task automatic test_overflow();
		logic [COEF_BITS-1:0] a[$];
		logic [COEF_BITS-1:0] b[$];
		for (int i = 0; i < CAP + 2; i++) a.push_back(rand_coef());
		for (int i = 0; i < CAP + 3; i++) b.push_back(rand_coef());
		send_poly(0, a, 1);
		send_poly(1, '{16'd3, 16'd1}, 1);
		send_poly(0, '{16'd1, 16'd1}, 1);
		send_poly(1, b, 1);
	endtask

	task automatic test_full_degree();
		for (int i = 0; i < 3; i++) send_pair(CAP);
	endtask

	task automatic test_modulus();
		logic [MOD_W-1:0] mods[$];
		mods = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'hFFFF, 16'd65519, 16'd251};
		foreach (mods[k]) begin
			write_modulus(mods[k]);
			for (int i = 0; i < 2; i++) send_pair(MAX_LEN);
		end
		write_modulus(MOD_RESET);
	endtask

	task automatic test_random(int target, int idle, int stall);
		int stop;
		send_idle_pct = idle;
		stall_pct     = stall;
		stop = words_sent + target;
		while (words_sent < stop) send_pair(MAX_LEN);
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = !hold_req;
		send_pair(3);
		send_pair(MAX_LEN);
		send_pair(MAX_LEN);
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		words_sent    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		field_mod     = MOD_RESET;
		first_len     = 0;
		second_len    = 0;
		trunc_seen    = 0;
		first_closed  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_overflow();
		test_full_degree();
		test_modulus();
		test_random(50, 0, 0);
		test_random(50, 46, 0);
		test_random(50, 0, 46);
		test_random(50, 32, 32);
		test_backpressure();

		@(negedge clk);
		item_valid <= 1'b0;
		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
